### rtl/core/lcs_pkg.sv
// shared types, constants and byte tables of the lcd command byte sequencer
package lcs_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned StepW      = 4;

  typedef enum logic [3:0] {
    CMD_WRITE      = 4'd0,
    CMD_ON         = 4'd1,
    CMD_OFF        = 4'd2,
    CMD_RESET      = 4'd3,
    CMD_NORMAL     = 4'd4,
    CMD_REVERSE    = 4'd5,
    CMD_ALLON      = 4'd6,
    CMD_ALLOFF     = 4'd7,
    CMD_ADC_NORM   = 4'd8,
    CMD_ADC_REV    = 4'd9,
    CMD_OUT_NORM   = 4'd10,
    CMD_OUT_REV    = 4'd11
  } cmd_e;

  typedef enum logic [1:0] {
    JOB_ERR  = 2'd0,
    JOB_ADDR = 2'd1,
    JOB_DATA = 2'd2
  } job_kind_e;

  typedef struct packed {
    logic       en;
    logic [7:0] val;
  } trail_t;

  typedef struct packed {
    job_kind_e  kind;
    logic [2:0] page;
    logic [6:0] column;
    logic [7:0] data;
    logic       init;
    trail_t     trail;
  } job_t;

  localparam logic [3:0] PageOp    = 4'hb;
  localparam logic [3:0] ColHighOp = 4'h1;
  localparam logic [3:0] ColLowOp  = 4'h0;

  localparam logic [StepW-1:0] StepAddrLast = StepW'(2);
  localparam logic [StepW-1:0] StepInitBase = StepW'(3);
  localparam logic [StepW-1:0] StepInitLast = StepW'(10);

  function automatic trail_t trail_of(input logic [3:0] cmd);
    trail_t t;
    t.en = 1'b1;
    unique case (cmd)
      CMD_ON:       t.val = 8'haf;
      CMD_OFF:      t.val = 8'hae;
      CMD_NORMAL:   t.val = 8'ha6;
      CMD_REVERSE:  t.val = 8'ha7;
      CMD_ALLON:    t.val = 8'ha5;
      CMD_ALLOFF:   t.val = 8'ha4;
      CMD_ADC_NORM: t.val = 8'ha0;
      CMD_ADC_REV:  t.val = 8'ha1;
      CMD_OUT_NORM: t.val = 8'hc0;
      CMD_OUT_REV:  t.val = 8'hc8;
      default: begin
        t.en  = 1'b0;
        t.val = 8'h00;
      end
    endcase
    return t;
  endfunction

  function automatic logic [7:0] init_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0: b = 8'ha0;
      3'd1: b = 8'h2f;
      3'd2: b = 8'ha2;
      3'd3: b = 8'hc8;
      3'd4: b = 8'h27;
      3'd5: b = 8'h81;
      3'd6: b = 8'h17;
      3'd7: b = 8'haf;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

### rtl/core/lcs_front.sv
// front end: accepts input words, tracks request state and issues jobs
module lcs_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic              req_type_i,
  input  logic [3:0]        page_i,
  input  logic [7:0]        column_i,
  input  logic [3:0]        command_i,
  input  logic              has_payload_i,
  input  logic [7:0]        data_byte_i,
  input  logic              last_payload_i,
  output logic              push_o,
  output lcs_pkg::job_t     job_o
);

  logic [3:0] pending_q, pending_d;
  logic       awaiting_q, awaiting_d;
  logic       discard_q, discard_d;
  logic       in_range;
  logic       is_reset;
  lcs_pkg::trail_t hdr_trail;
  lcs_pkg::trail_t pay_trail;

  assign in_range  = (page_i[3] == 1'b0) && (column_i[7] == 1'b0);
  assign is_reset  = (command_i == lcs_pkg::CMD_RESET);
  assign hdr_trail = lcs_pkg::trail_of(command_i);
  assign pay_trail = lcs_pkg::trail_of(pending_q);

  always_comb begin
    pending_d    = pending_q;
    awaiting_d   = awaiting_q;
    discard_d    = discard_q;
    push_o       = 1'b0;
    job_o.kind   = lcs_pkg::JOB_ADDR;
    job_o.page   = page_i[2:0];
    job_o.column = column_i[6:0];
    job_o.data   = data_byte_i;
    job_o.init   = 1'b0;
    job_o.trail  = '0;
    if (accept_i) begin
      if (req_type_i == 1'b0) begin
        push_o     = 1'b1;
        pending_d  = '0;
        awaiting_d = 1'b0;
        discard_d  = 1'b0;
        if (!in_range) begin
          job_o.kind = lcs_pkg::JOB_ERR;
          discard_d  = has_payload_i;
        end else if (is_reset) begin
          job_o.init = 1'b1;
          discard_d  = has_payload_i;
        end else if (has_payload_i) begin
          pending_d  = command_i;
          awaiting_d = 1'b1;
        end else begin
          job_o.trail = hdr_trail;
        end
      end else if (awaiting_q) begin
        push_o     = 1'b1;
        job_o.kind = lcs_pkg::JOB_DATA;
        if (last_payload_i) begin
          job_o.trail = pay_trail;
          awaiting_d  = 1'b0;
          pending_d   = '0;
        end
      end else if (discard_q && last_payload_i) begin
        discard_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q  <= '0;
      awaiting_q <= 1'b0;
      discard_q  <= 1'b0;
    end else begin
      pending_q  <= pending_d;
      awaiting_q <= awaiting_d;
      discard_q  <= discard_d;
    end
  end

endmodule

### rtl/core/lcs_queue.sv
// job queue between front end and byte sequencer
module lcs_queue #(
  parameter int unsigned Depth = lcs_pkg::QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  lcs_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output lcs_pkg::job_t job_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

  lcs_pkg::job_t   mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign job_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

### rtl/core/lcs_back.sv
// back end: expands each job into output words through a step counter
module lcs_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  input  lcs_pkg::job_t job_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    out_byte_o,
  output logic          is_display_data_o,
  output logic          last_of_run_o,
  output logic          range_error_o
);

  localparam int unsigned StepW = lcs_pkg::StepW;

  logic [StepW-1:0] step_q, step_d;
  logic [StepW-1:0] final_step;
  logic [StepW-1:0] init_off;
  logic             load;
  logic             fire;
  logic             last;
  logic [7:0]       cur_byte;
  logic             cur_dd;
  logic             cur_err;
  logic             valid_q;
  logic [7:0]       byte_q;
  logic             dd_q;
  logic             last_q;
  logic             err_q;

  assign load     = !valid_q || out_ready_i;
  assign fire     = load && job_valid_i;
  assign init_off = step_q - lcs_pkg::StepInitBase;

  always_comb begin
    final_step = '0;
    cur_byte   = 8'h00;
    cur_dd     = 1'b0;
    cur_err    = 1'b0;
    unique case (job_i.kind)
      lcs_pkg::JOB_ERR: begin
        cur_err = 1'b1;
      end
      lcs_pkg::JOB_DATA: begin
        final_step = job_i.trail.en ? StepW'(1) : '0;
        if (step_q == '0) begin
          cur_byte = job_i.data;
          cur_dd   = 1'b1;
        end else begin
          cur_byte = job_i.trail.val;
        end
      end
      lcs_pkg::JOB_ADDR: begin
        if (job_i.init) begin
          final_step = lcs_pkg::StepInitLast + StepW'(job_i.trail.en);
        end else begin
          final_step = lcs_pkg::StepAddrLast + StepW'(job_i.trail.en);
        end
        if (step_q == '0) begin
          cur_byte = {lcs_pkg::PageOp, 1'b0, job_i.page};
        end else if (step_q == StepW'(1)) begin
          cur_byte = {lcs_pkg::ColLowOp, job_i.column[3:0]};
        end else if (step_q == lcs_pkg::StepAddrLast) begin
          cur_byte = {lcs_pkg::ColHighOp, 1'b0, job_i.column[6:4]};
        end else if (job_i.init && step_q <= lcs_pkg::StepInitLast) begin
          cur_byte = lcs_pkg::init_byte(init_off[2:0]);
        end else begin
          cur_byte = job_i.trail.val;
        end
      end
      default: begin
        cur_err = 1'b1;
      end
    endcase
  end

  assign last  = (step_q == final_step);
  assign pop_o = fire && last;

  always_comb begin
    step_d = step_q;
    if (fire) begin
      step_d = last ? '0 : step_q + StepW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      if (load) begin
        valid_q <= job_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      byte_q <= cur_byte;
      dd_q   <= cur_dd;
      last_q <= last;
      err_q  <= cur_err;
    end
  end

  assign out_valid_o       = valid_q;
  assign out_byte_o        = byte_q;
  assign is_display_data_o = dd_q;
  assign last_of_run_o     = last_q;
  assign range_error_o     = err_q;

endmodule

### rtl/core/lcd_command_byte_sequencer_top.sv
// top level of the lcd command byte sequencer
// the first output word is held in the job queue and then in the output register after the input word is accepted
// throughput: one output word per cycle while out_ready_i is high; a payload word gives one or two output words,
// a header one to eleven, one output word per step of the step counter
// input is taken while the job queue has room, so headers stall it as they drain
// reset clears request state, queue, step counter and output valid flag; no clearing pass
module lcd_command_byte_sequencer_top #(
  parameter int unsigned QueueDepth = lcs_pkg::QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       req_type_i,
  input  logic [3:0] page_i,
  input  logic [7:0] column_i,
  input  logic [3:0] command_i,
  input  logic       has_payload_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_payload_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       is_display_data_o,
  output logic       last_of_run_o,
  output logic       range_error_o
);

  logic          accept;
  logic          push;
  logic          full;
  logic          pop;
  logic          job_valid;
  lcs_pkg::job_t front_job;
  lcs_pkg::job_t head_job;

  assign in_ready_o = !full;
  assign accept     = in_valid_i && in_ready_o;

  lcs_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .req_type_i     (req_type_i),
    .page_i         (page_i),
    .column_i       (column_i),
    .command_i      (command_i),
    .has_payload_i  (has_payload_i),
    .data_byte_i    (data_byte_i),
    .last_payload_i (last_payload_i),
    .push_o         (push),
    .job_o          (front_job)
  );

  lcs_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (front_job),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (job_valid),
    .job_o   (head_job)
  );

  lcs_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .job_valid_i       (job_valid),
    .job_i             (head_job),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .out_byte_o        (out_byte_o),
    .is_display_data_o (is_display_data_o),
    .last_of_run_o     (last_of_run_o),
    .range_error_o     (range_error_o)
  );

`ifndef NO_ASSERTIONS
  a_err_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && range_error_o |->
      last_of_run_o && !is_display_data_o && out_byte_o == 8'h00)
    else $error("error word malformed");

  a_pop_has_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> job_valid)
    else $error("pop from empty queue");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full)
    else $error("push into full queue");

  a_pop_sets_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> out_valid_o && last_of_run_o)
    else $error("job end without last word");
`endif

endmodule
